// File: hdl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types, constants and the half-step coil table for the slot stepper
// positioner.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam logic [2:0]  SLOT_COUNT    = 3'd6;
    localparam logic [15:0] PERIOD_RESET  = 16'd1126;
    localparam logic [2:0]  SLOT_RESET    = 3'd1;
    localparam logic [2:0]  PHASE_CW_FIRST  = 3'd0;
    localparam logic [2:0]  PHASE_CCW_FIRST = 3'd7;

    // half steps per move of one, two and three slots (85, 170, 256 sequences)
    localparam logic [11:0] STEPS_ONE   = 12'd680;
    localparam logic [11:0] STEPS_TWO   = 12'd1360;
    localparam logic [11:0] STEPS_THREE = 12'd2048;

    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_MOVE = 1'b1;

    typedef struct packed {
        logic       action;
        logic [2:0] target_slot;
    } ssp_cmd_t;

    typedef struct packed {
        logic [3:0] coils;
        logic       busy_res;
        logic [2:0] current_slot;
        logic       accepted;
    } ssp_res_t;

    function automatic logic [3:0] phase_coils(input logic [2:0] phase);
        logic [3:0] pattern;
        unique case (phase)
            3'd0:    pattern = 4'h1;
            3'd1:    pattern = 4'h3;
            3'd2:    pattern = 4'h2;
            3'd3:    pattern = 4'h6;
            3'd4:    pattern = 4'h4;
            3'd5:    pattern = 4'hC;
            3'd6:    pattern = 4'h8;
            default: pattern = 4'h9;
        endcase
        return pattern;
    endfunction

    function automatic logic [11:0] move_steps(input logic [1:0] slots);
        logic [11:0] steps;
        unique case (slots)
            2'd1:    steps = STEPS_ONE;
            2'd2:    steps = STEPS_TWO;
            default: steps = STEPS_THREE;
        endcase
        return steps;
    endfunction

endpackage

// File: hdl/ssp_step.sv
// ----------------------------------------------------------------------------
// ssp_step
// Positioner state and its single-pass update: move start, tick counting,
// phase advance and move completion.
// ----------------------------------------------------------------------------
module ssp_step
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  ssp_pkg::ssp_cmd_t   cmd,
    input  logic [15:0]         period,
    output ssp_pkg::ssp_res_t   res
);

    logic [2:0]  slot_now_reg,  slot_now_next;
    logic [2:0]  phase_reg,     phase_next;
    logic [11:0] steps_left_reg, steps_left_next;
    logic [15:0] tick_reg,      tick_next;
    logic        cw_reg,        cw_next;
    logic        moving_reg,    moving_next;
    logic [2:0]  goal_reg,      goal_next;
    logic [3:0]  coil_reg,      coil_next;

    logic [3:0]  cw_gap_sum;
    logic [3:0]  cw_gap;
    logic [1:0]  move_slots;
    logic        target_ok;
    logic        start;
    logic        period_done;
    logic [11:0] steps_dec;
    logic [2:0]  phase_adv;

    always_comb
    begin
        cw_gap_sum = {1'b0, cmd.target_slot} + {1'b0, ssp_pkg::SLOT_COUNT}
                     - {1'b0, slot_now_reg};
        cw_gap = (cw_gap_sum >= {1'b0, ssp_pkg::SLOT_COUNT})
                 ? cw_gap_sum - {1'b0, ssp_pkg::SLOT_COUNT} : cw_gap_sum;
        move_slots = (cw_gap <= 4'd3) ? cw_gap[1:0]
                     : 2'(4'(ssp_pkg::SLOT_COUNT) - cw_gap);
        target_ok = (cmd.target_slot != 3'd0) && (cmd.target_slot != 3'd7)
                    && (cmd.target_slot != slot_now_reg);
        start = (cmd.action == ssp_pkg::ACTION_MOVE) && !moving_reg && target_ok;

        period_done = ({1'b0, tick_reg} + 17'd1) >= {1'b0, period};
        steps_dec = steps_left_reg - 12'd1;
        phase_adv = cw_reg ? phase_reg + 3'd1 : phase_reg - 3'd1;

        slot_now_next   = slot_now_reg;
        phase_next      = phase_reg;
        steps_left_next = steps_left_reg;
        tick_next       = tick_reg;
        cw_next         = cw_reg;
        moving_next     = moving_reg;
        goal_next       = goal_reg;
        coil_next       = coil_reg;

        if (cmd.action == ssp_pkg::ACTION_MOVE)
        begin
            if (start)
            begin
                cw_next         = (cw_gap <= 4'd3);
                phase_next      = (cw_gap <= 4'd3) ? ssp_pkg::PHASE_CW_FIRST
                                                   : ssp_pkg::PHASE_CCW_FIRST;
                steps_left_next = ssp_pkg::move_steps(move_slots);
                tick_next       = 16'd0;
                goal_next       = cmd.target_slot;
                moving_next     = 1'b1;
                coil_next       = ssp_pkg::phase_coils(phase_next);
            end
        end
        else if (moving_reg)
        begin
            if (period_done)
            begin
                tick_next       = 16'd0;
                steps_left_next = steps_dec;
                if (steps_dec == 12'd0)
                begin
                    moving_next   = 1'b0;
                    slot_now_next = goal_reg;
                end
                else
                begin
                    phase_next = phase_adv;
                    coil_next  = ssp_pkg::phase_coils(phase_adv);
                end
            end
            else
            begin
                tick_next = tick_reg + 16'd1;
            end
        end

        res.coils        = coil_next;
        res.busy_res     = moving_next;
        res.current_slot = slot_now_next;
        res.accepted     = start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_now_reg   <= ssp_pkg::SLOT_RESET;
            phase_reg      <= 3'd0;
            steps_left_reg <= 12'd0;
            tick_reg       <= 16'd0;
            cw_reg         <= 1'b0;
            moving_reg     <= 1'b0;
            goal_reg       <= ssp_pkg::SLOT_RESET;
            coil_reg       <= 4'd0;
        end
        else if (fire)
        begin
            slot_now_reg   <= slot_now_next;
            phase_reg      <= phase_next;
            steps_left_reg <= steps_left_next;
            tick_reg       <= tick_next;
            cw_reg         <= cw_next;
            moving_reg     <= moving_next;
            goal_reg       <= goal_next;
            coil_reg       <= coil_next;
        end
    end

endmodule

// File: hdl/slot_stepper_positioner_core.sv
// ----------------------------------------------------------------------------
// slot_stepper_positioner_core
// Six-slot carousel positioner driving a unipolar stepper in half steps.
// ----------------------------------------------------------------------------
// Each transfer on cmd is either one time-base tick or a move command and
// yields exactly one transfer on res. The block takes one cmd transfer per
// clock cycle while no result waits on res_ready; a command passes the input
// register and one pass of update logic into the result register, which lets
// the next command enter while a result waits for res_ready. Moves take the
// shorter way round, 680, 1360 or 2048 half steps for one to three slots,
// each pattern held for half_step_period ticks (written through cfg_wr_en and
// cfg_wr_data, reset value 1126). Commands while busy or to the current slot
// are not accepted.
module slot_stepper_positioner_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  ssp_pkg::ssp_cmd_t cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output ssp_pkg::ssp_res_t res,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data
);

    ssp_pkg::ssp_cmd_t cmd_reg;
    logic              cmd_valid_reg;
    ssp_pkg::ssp_res_t res_reg;
    ssp_pkg::ssp_res_t step_res;
    logic              res_valid_reg;
    logic [15:0]       period_reg;
    logic              advance;

    assign advance   = cmd_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !cmd_valid_reg || advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    ssp_step u_step
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .cmd    (cmd_reg),
        .period (period_reg),
        .res    (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            period_reg    <= ssp_pkg::PERIOD_RESET;
        end
        else
        begin
            if (cmd_ready)
            begin
                cmd_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    // a started move is always reported busy
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.accepted |-> res.busy_res)
        else $error("accepted move not busy");

    // reported slot stays within the carousel
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.current_slot != 3'd0) && (res.current_slot != 3'd7))
        else $error("current slot out of range");

    // input stalls only behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> cmd_valid_reg && res_valid_reg && !res_ready)
        else $error("input stalled without back pressure");

    // a held result stays until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result dropped or changed while stalled");

endmodule
